/* src/lsvr_pkg.sv */
package lsvr_pkg;

  // Default build parameters.
  localparam int DEF_STORE_FRAMES = 4096;
  localparam int DEF_FRAC_BITS    = 8;

  // Play position width, two's complement fixed point.
  localparam int POS_BITS = 22;

  // Saturation limit of the output samples.
  localparam logic signed [15:0] SAT_MAX = 16'sh7FFF;

  // Stream payload widths.
  localparam int IN_DATA_W  = 32;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 32;
  localparam int OUT_USER_W = 1;

  // Configuration port widths.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 17;

  // Operation codes carried in the input tuser.
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;
  localparam logic [1:0] OP_STOP  = 2'd3;

  // Play modes.
  localparam logic [1:0] MODE_ONCE  = 2'd0;
  localparam logic [1:0] MODE_LOOP  = 2'd1;
  localparam logic [1:0] MODE_BIDIR = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_LENGTH     = 3'd0;
  localparam logic [2:0] CFG_LOOP_START = 3'd1;
  localparam logic [2:0] CFG_LOOP_END   = 3'd2;
  localparam logic [2:0] CFG_STEP       = 3'd3;
  localparam logic [2:0] CFG_MODE       = 3'd4;
  localparam logic [2:0] CFG_INTERP     = 3'd5;
  localparam logic [2:0] CFG_LEFT_GAIN  = 3'd6;
  localparam logic [2:0] CFG_RIGHT_GAIN = 3'd7;

  // Configuration reset values.
  localparam logic [12:0] RST_LENGTH     = 13'd4096;
  localparam logic [11:0] RST_LOOP_START = 12'd0;
  localparam logic [12:0] RST_LOOP_END   = 13'd4096;
  localparam logic [16:0] RST_STEP       = 17'd256;
  localparam logic [1:0]  RST_MODE       = MODE_ONCE;
  localparam logic        RST_INTERP     = 1'b1;
  localparam logic [15:0] RST_LEFT_GAIN  = 16'd23170;
  localparam logic [15:0] RST_RIGHT_GAIN = 16'd23170;

endpackage

/* src/lsvr_mod_unit.sv */
module lsvr_mod_unit #(
  parameter int W = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [W-1:0] dividend,
  input  logic        [W-1:0] divisor,
  output logic                done,
  output logic        [W-1:0] remainder
);

  localparam int CW = $clog2(W + 1);

  // Restoring division, one quotient bit per cycle, then a sign fix so the
  // remainder always lies in 0 .. divisor-1.
  logic [W-1:0]  dvd;
  logic [W-1:0]  rem;
  logic [W-1:0]  dvs;
  logic          neg;
  logic          busy;
  logic          fixing;
  logic [CW-1:0] cnt;
  logic [W:0]    shifted;
  logic [W+1:0]  diff;
  logic [W-1:0]  rem_next;

  always_comb begin
    shifted  = {rem, dvd[W-1]};
    diff     = {1'b0, shifted} - {2'b00, dvs};
    rem_next = diff[W+1] ? shifted[W-1:0] : diff[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      fixing <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        fixing <= 1'b0;
        neg    <= dividend[W-1];
        dvd    <= dividend[W-1] ? W'(-dividend) : W'(dividend);
        rem    <= '0;
        dvs    <= divisor;
        cnt    <= CW'(W);
      end else if (busy) begin
        rem <= rem_next;
        dvd <= {dvd[W-2:0], 1'b0};
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy   <= 1'b0;
          fixing <= 1'b1;
        end
      end else if (fixing) begin
        fixing    <= 1'b0;
        done      <= 1'b1;
        remainder <= (neg && (rem != '0)) ? (dvs - rem) : rem;
      end
    end
  end

endmodule

/* src/looping_sample_voice_resampler_core.sv */
// One sample playback voice with a local store of signed 16-bit mono frames.
// Input transactions arrive on the s_ channel: tuser carries the operation
// (write a frame, tick, start, stop), tdata the frame address and sample.
// Writes, start and stop leave the voice idle and give no result. Each
// tick gives exactly one result transaction on the m_ channel: the left and
// right samples in tdata and the playing flag after the tick in tuser.
// Configuration must be written through cfg_we / cfg_index / cfg_data only
// while the voice is idle; the block itself does not enforce this. A write
// takes effect at the next clock edge. A tick runs through a sequencer
// around the sample memory (one write, one read port): bounds, position
// check, two frame reads, two interpolation products, two gain products and
// saturation. For a tick whose position stays inside its region, s_tready
// returns with the result; a tick that must wrap or fold the position adds
// the modulo unit and the fold step. A tick while stopped gives a silent
// result, and a once-mode tick that ends playback stops and rewinds at the
// position check. Reset clears the position, direction, playing flag and
// m_tvalid and loads the configuration reset values; the sample store keeps
// its contents and must be written before it is read. If the receiver
// stalls, the result is held in the output register and the next
// transaction is still accepted; a following tick then waits at its last step.
module looping_sample_voice_resampler_core #(
  parameter int STORE_FRAMES = lsvr_pkg::DEF_STORE_FRAMES,
  parameter int FRAC_BITS    = lsvr_pkg::DEF_FRAC_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  // Input transactions.
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // s_tdata: frame_address [11:0], sample_value [27:12], zero fill [31:28].
  input  logic [lsvr_pkg::IN_DATA_W-1:0]     s_tdata,
  // s_tuser: operation [1:0].
  input  logic [lsvr_pkg::IN_USER_W-1:0]     s_tuser,
  // Result transactions.
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // m_tdata: left_out [15:0], right_out [31:16].
  output logic [lsvr_pkg::OUT_DATA_W-1:0]    m_tdata,
  // m_tuser: still_playing [0].
  output logic [lsvr_pkg::OUT_USER_W-1:0]    m_tuser,
  // Configuration write port.
  input  logic                               cfg_we,
  input  logic [lsvr_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [lsvr_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import lsvr_pkg::*;

  localparam int AW   = $clog2(STORE_FRAMES);
  // Internal position word: holds the sign-extended play position and twice
  // the largest region in fixed point.
  localparam int EW   = ((POS_BITS > 14 + FRAC_BITS) ? POS_BITS : 14 + FRAC_BITS) + 2;
  localparam int ACCW = 17 + FRAC_BITS;
  localparam int PW   = ACCW + 17;
  localparam int SH   = FRAC_BITS + 15;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_BOUND = 12'b000000000010,
    S_CHECK = 12'b000000000100,
    S_DIV   = 12'b000000001000,
    S_FIX   = 12'b000000010000,
    S_READ1 = 12'b000000100000,
    S_READ2 = 12'b000001000000,
    S_MUL2  = 12'b000010000000,
    S_GAINL = 12'b000100000000,
    S_GAINR = 12'b001000000000,
    S_SATR  = 12'b010000000000,
    S_OUT   = 12'b100000000000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [12:0] length_frames;
  logic [11:0] loop_start_frame;
  logic [12:0] loop_end_frame;
  logic [16:0] step_size;
  logic [1:0]  play_mode;
  logic        interpolation;
  logic [15:0] left_gain;
  logic [15:0] right_gain;

  // Voice state.
  logic [POS_BITS-1:0] play_position;
  logic                reverse_direction;
  logic                playing;

  // Input fields.
  logic [1:0]         operation;
  logic [11:0]        frame_address;
  logic signed [15:0] sample_value;
  logic               in_accept;

  assign operation     = s_tuser[1:0];
  assign frame_address = s_tdata[11:0];
  assign sample_value  = s_tdata[27:12];
  assign s_tready      = (state == S_IDLE);
  assign in_accept     = s_tvalid && s_tready;

  // Sample store.
  logic signed [15:0] mem [STORE_FRAMES];
  logic               mem_we;
  logic [AW-1:0]      rd_addr;
  logic signed [15:0] rd_data;

  assign mem_we = in_accept && (operation == OP_WRITE) &&
                  (32'(frame_address) < 32'(STORE_FRAMES));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[AW'(frame_address)] <= sample_value;
    end
    rd_data <= mem[rd_addr];
  end

  // Region bounds, clamped to the store and registered at the start of a tick.
  logic [EW-1:0] len_c, ls_c, le_c;
  logic [1:0]    mode_c;

  always_comb begin
    len_c = EW'(length_frames);
    if (len_c > EW'(STORE_FRAMES)) begin
      len_c = EW'(STORE_FRAMES);
    end
    ls_c = EW'(loop_start_frame);
    if (ls_c > EW'(STORE_FRAMES - 1)) begin
      ls_c = EW'(STORE_FRAMES - 1);
    end
    le_c = EW'(loop_end_frame);
    if (le_c > EW'(STORE_FRAMES)) begin
      le_c = EW'(STORE_FRAMES);
    end
    if (le_c <= ls_c) begin
      le_c = ls_c + EW'(1);
    end
    case (play_mode)
      MODE_LOOP, MODE_BIDIR: mode_c = play_mode;
      default:               mode_c = MODE_ONCE;
    endcase
  end

  logic [1:0]    mode;
  logic [EW-1:0] len_fp, ls_fp, reg_fp, per_fp, end_fp;
  logic [AW-1:0] ls_frame, le_last_frame;

  // Working registers of one tick.
  logic signed [EW-1:0] pos_w;
  logic                 u_above;
  logic [AW-1:0]        nb;
  logic [FRAC_BITS-1:0] frac;
  logic signed [ACCW-1:0] p1;
  logic signed [ACCW-1:0] acc;
  logic signed [PW-1:0]   prod;
  logic signed [15:0]     left_r, right_r;
  logic                   still_r;

  // Position checks against the region.
  logic signed [EW-1:0] pos_s, u_s;
  logic                 once_out, region_out;

  always_comb begin
    pos_s      = EW'(signed'(play_position));
    u_s        = pos_s - signed'(ls_fp);
    once_out   = (pos_s < 0) || (pos_s >= signed'(len_fp));
    region_out = (u_s < 0) || (u_s >= signed'(reg_fp));
  end

  // Modulo unit for loop wrap and bidirectional fold.
  logic          div_start, div_done;
  logic [EW-1:0] div_rem;

  assign div_start = (state == S_CHECK) && (mode != MODE_ONCE) && region_out;

  lsvr_mod_unit #(
    .W(EW)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (u_s),
    .divisor  ((mode == MODE_LOOP) ? reg_fp : per_fp),
    .done     (div_done),
    .remainder(div_rem)
  );

  // Folded position: a remainder in the upper half of the period mirrors back.
  logic          fold_high;
  logic [EW-1:0] fold_off;

  always_comb begin
    fold_high = (div_rem >= reg_fp);
    fold_off  = fold_high ? (per_fp - div_rem) : div_rem;
  end

  // Frame index and neighbor for the current position.
  logic [AW-1:0]        idx_c, nb_c;
  logic [FRAC_BITS-1:0] frac_c;
  logic                 at_end;

  always_comb begin
    idx_c  = pos_w[FRAC_BITS +: AW];
    frac_c = interpolation ? pos_w[FRAC_BITS-1:0] : '0;
    at_end = (pos_w + (EW'(1) <<< FRAC_BITS)) >= signed'(end_fp);
    if (at_end) begin
      case (mode)
        MODE_LOOP:  nb_c = ls_frame;
        MODE_BIDIR: nb_c = le_last_frame;
        default:    nb_c = idx_c;
      endcase
    end else begin
      nb_c = idx_c + AW'(1);
    end
  end

  always_comb begin
    case (state)
      S_READ1: rd_addr = idx_c;
      S_READ2: rd_addr = nb;
      default: rd_addr = idx_c;
    endcase
  end

  // Interpolation weights and step.
  logic [FRAC_BITS:0]   one_minus;
  logic signed [17:0]   step_c;
  logic signed [EW-1:0] pos_adv;

  always_comb begin
    one_minus = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, frac};
    step_c    = 18'(signed'(step_size));
    if (step_c == 18'sd0) begin
      step_c = 18'sd1;
    end
    if ((mode == MODE_BIDIR) && reverse_direction) begin
      step_c = -step_c;
    end
    pos_adv = pos_w + EW'(step_c);
  end

  // Rounding and saturation of a gain product.
  logic signed [PW-1:0] rounded;
  logic signed [15:0]   sat_c;

  always_comb begin
    rounded = (prod + (PW'(1) <<< (SH - 1))) >>> SH;
    if (rounded > PW'(SAT_MAX)) begin
      sat_c = SAT_MAX;
    end else if (rounded < -PW'(SAT_MAX) - PW'(1)) begin
      sat_c = -SAT_MAX - 16'sd1;
    end else begin
      sat_c = rounded[15:0];
    end
  end

  // The output register takes a new result when it is empty or being drained.
  logic out_load;

  assign out_load = (state == S_OUT) && (!m_tvalid || m_tready);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      length_frames    <= RST_LENGTH;
      loop_start_frame <= RST_LOOP_START;
      loop_end_frame   <= RST_LOOP_END;
      step_size        <= RST_STEP;
      play_mode        <= RST_MODE;
      interpolation    <= RST_INTERP;
      left_gain        <= RST_LEFT_GAIN;
      right_gain       <= RST_RIGHT_GAIN;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LENGTH:     length_frames    <= cfg_data[12:0];
        CFG_LOOP_START: loop_start_frame <= cfg_data[11:0];
        CFG_LOOP_END:   loop_end_frame   <= cfg_data[12:0];
        CFG_STEP:       step_size        <= cfg_data[16:0];
        CFG_MODE:       play_mode        <= cfg_data[1:0];
        CFG_INTERP:     interpolation    <= cfg_data[0];
        CFG_LEFT_GAIN:  left_gain        <= cfg_data[15:0];
        CFG_RIGHT_GAIN: right_gain       <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Tick sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      play_position     <= '0;
      reverse_direction <= 1'b0;
      playing           <= 1'b0;
      m_tvalid          <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            case (operation)
              OP_TICK:  state   <= S_BOUND;
              OP_START: playing <= 1'b1;
              OP_STOP:  playing <= 1'b0;
              default: ;
            endcase
          end
        end
        S_BOUND: begin
          mode          <= mode_c;
          len_fp        <= len_c << FRAC_BITS;
          ls_fp         <= ls_c << FRAC_BITS;
          reg_fp        <= (le_c - ls_c) << FRAC_BITS;
          per_fp        <= ((le_c - ls_c) << (FRAC_BITS + 1)) - EW'(1);
          end_fp        <= ((mode_c == MODE_ONCE) ? len_c : le_c) << FRAC_BITS;
          ls_frame      <= AW'(ls_c);
          le_last_frame <= AW'(le_c - EW'(1));
          if (playing) begin
            state <= S_CHECK;
          end else begin
            left_r  <= '0;
            right_r <= '0;
            still_r <= 1'b0;
            state   <= S_OUT;
          end
        end
        S_CHECK: begin
          pos_w   <= pos_s;
          u_above <= (u_s > 0);
          if (mode == MODE_ONCE) begin
            if (once_out) begin
              // Outside the one-shot region: stop, rewind, give silence.
              playing       <= 1'b0;
              play_position <= '0;
              left_r        <= '0;
              right_r       <= '0;
              still_r       <= 1'b0;
              state         <= S_OUT;
            end else begin
              state <= S_READ1;
            end
          end else if (region_out) begin
            state <= S_DIV;
          end else begin
            state <= S_READ1;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_FIX;
          end
        end
        S_FIX: begin
          if (mode == MODE_LOOP) begin
            pos_w <= signed'(ls_fp + div_rem);
          end else begin
            pos_w <= signed'(ls_fp + fold_off);
            // An odd number of reflections reverses the direction; landing on
            // the start from above counts as odd.
            if (fold_high || ((div_rem == '0) && u_above)) begin
              reverse_direction <= ~reverse_direction;
            end
          end
          state <= S_READ1;
        end
        S_READ1: begin
          nb    <= nb_c;
          frac  <= frac_c;
          state <= S_READ2;
        end
        S_READ2: begin
          p1    <= ACCW'(rd_data * signed'({1'b0, one_minus}));
          state <= S_MUL2;
        end
        S_MUL2: begin
          acc           <= p1 + ACCW'(rd_data * signed'({1'b0, frac}));
          play_position <= POS_BITS'(pos_adv);
          state         <= S_GAINL;
        end
        S_GAINL: begin
          prod  <= PW'(acc * signed'({1'b0, left_gain}));
          state <= S_GAINR;
        end
        S_GAINR: begin
          left_r <= sat_c;
          prod   <= PW'(acc * signed'({1'b0, right_gain}));
          state  <= S_SATR;
        end
        S_SATR: begin
          right_r <= sat_c;
          still_r <= playing;
          state   <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            m_tdata  <= {right_r, left_r};
            m_tuser  <= still_r;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
